// ----- rtl/point_rotation_about_pivot_core_defines.svh -----
// Assertion macros for the point rotation core.
// Included by modules that carry concurrent checks; needs no other file.
`ifndef POINT_ROTATION_ABOUT_PIVOT_CORE_DEFINES_SVH
`define POINT_ROTATION_ABOUT_PIVOT_CORE_DEFINES_SVH

// same-cycle implication
`define PRAP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("point rotation check failed");

// next-cycle implication
`define PRAP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("point rotation check failed");

`endif

// ----- rtl/prap_pkg.sv -----
// Package for the point rotation core: widths, request and result types,
// CORDIC constants and the arctangent step table. Depends on nothing.
`timescale 1ns / 1ps

package prap_pkg;

	localparam int COORD_BITS     = 16;
	localparam int TRIG_FRAC_BITS = 15;
	localparam int ANGLE_BITS     = 13;
	localparam int FULL_TURN      = 5760;
	localparam int HALF_TURN      = 2880;
	localparam int QUARTER_TURN   = 1440;
	localparam int ANGLE_SHIFT    = 12;
	localparam int CORDIC_FRAC    = 30;
	localparam int CORDIC_STEPS   = 24;
	localparam int XW             = CORDIC_FRAC + 2;
	localparam int ZW             = 25;

	localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);

	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic signed [COORD_BITS-1:0] pivot_x;
		logic signed [COORD_BITS-1:0] pivot_y;
		logic        [ANGLE_BITS-1:0] angle_q4;
	} point_req_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] rotated_x;
		logic signed [COORD_BITS-1:0] rotated_y;
	} point_rsp_t;

	// atan(2^-i) in degrees, scaled by 65536
	function automatic logic signed [ZW-1:0] atan_step(input int unsigned i);
		logic signed [ZW-1:0] r;
		unique case (i)
			0:       r = ZW'(2949120);
			1:       r = ZW'(1740967);
			2:       r = ZW'(919879);
			3:       r = ZW'(466945);
			4:       r = ZW'(234379);
			5:       r = ZW'(117304);
			6:       r = ZW'(58666);
			7:       r = ZW'(29335);
			8:       r = ZW'(14668);
			9:       r = ZW'(7334);
			10:      r = ZW'(3667);
			11:      r = ZW'(1833);
			12:      r = ZW'(917);
			13:      r = ZW'(458);
			14:      r = ZW'(229);
			15:      r = ZW'(115);
			16:      r = ZW'(57);
			17:      r = ZW'(29);
			18:      r = ZW'(14);
			19:      r = ZW'(7);
			20:      r = ZW'(4);
			21:      r = ZW'(2);
			22:      r = ZW'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/point_rotation_about_pivot_core.sv -----
// Pipelined; accepts one request per cycle while no stalled result holds the pipeline.
// Depth is set by the 24-stage CORDIC that makes cosine and sine for each angle.
// A stalled result holds the whole pipeline; bubbles advance while no result waits.
// Reset (arst_n low, asynchronous) clears all valid bits; payload is not reset.
// Uses prap_pkg and point_rotation_about_pivot_core_defines.svh.
`timescale 1ns / 1ps
`include "point_rotation_about_pivot_core_defines.svh"

module point_rotation_about_pivot_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 src_valid,
	output logic                 src_stall,
	input  prap_pkg::point_req_t src,
	output logic                 dst_valid,
	input  logic                 dst_stall,
	output prap_pkg::point_rsp_t dst
);

	localparam int CW    = prap_pkg::COORD_BITS;
	localparam int TF    = prap_pkg::TRIG_FRAC_BITS;
	localparam int XW    = prap_pkg::XW;
	localparam int ZW    = prap_pkg::ZW;
	localparam int NS    = prap_pkg::CORDIC_STEPS;
	localparam int AB    = prap_pkg::ANGLE_BITS;
	localparam int AXW   = AB + 1;
	localparam int DW    = CW + 1;
	localparam int TW    = TF + 2;
	localparam int PW    = DW + TW;
	localparam int SW    = PW + 1;
	localparam int RW    = SW - TF;
	localparam int AW    = RW + 1;
	localparam int DROP  = prap_pkg::CORDIC_FRAC - TF;

	localparam logic signed [XW-1:0] HALF_X  = XW'(1) <<< (DROP - 1);
	localparam logic signed [SW-1:0] HALF_T  = SW'(1) <<< (TF - 1);
	localparam logic signed [TW-1:0] ONE_T   = TW'(1) <<< TF;
	localparam logic signed [TW-1:0] NONE_T  = -ONE_T;
	localparam logic signed [AW-1:0] MAX_C   = AW'((1 << (CW - 1)) - 1);
	localparam logic signed [AW-1:0] MIN_C   = -MAX_C - AW'(1);

	logic adv;

	assign adv       = !dst_valid || !dst_stall;
	assign src_stall = !adv;

	// angle wrap and fold into [-90, +90] degrees
	logic        [AB-1:0]  ang_wrap;
	logic signed [AXW-1:0] ang_c;
	logic signed [AXW-1:0] ang_f;
	logic                  neg_d;

	always_comb begin
		ang_wrap = (src.angle_q4 >= AB'(prap_pkg::FULL_TURN)) ?
			src.angle_q4 - AB'(prap_pkg::FULL_TURN) : src.angle_q4;
		ang_c = signed'({1'b0, ang_wrap});
		if (ang_c > AXW'(prap_pkg::HALF_TURN)) begin
			ang_c = ang_c - AXW'(prap_pkg::FULL_TURN);
		end
		priority if (ang_c > AXW'(prap_pkg::QUARTER_TURN)) begin
			ang_f = ang_c - AXW'(prap_pkg::HALF_TURN);
			neg_d = 1'b1;
		end else if (ang_c < -AXW'(prap_pkg::QUARTER_TURN)) begin
			ang_f = ang_c + AXW'(prap_pkg::HALF_TURN);
			neg_d = 1'b1;
		end else begin
			ang_f = ang_c;
			neg_d = 1'b0;
		end
	end

	// CORDIC stage registers; index 0 is the entry stage
	logic                 v_s   [0:NS];
	logic signed [XW-1:0] cx_s  [0:NS];
	logic signed [XW-1:0] cy_s  [0:NS];
	logic signed [ZW-1:0] cz_s  [0:NS-1];
	logic                 neg_s [0:NS];
	logic signed [DW-1:0] dx_s  [0:NS];
	logic signed [DW-1:0] dy_s  [0:NS];
	logic signed [CW-1:0] pvx_s [0:NS];
	logic signed [CW-1:0] pvy_s [0:NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s[0]  <= prap_pkg::CORDIC_GAIN;
			cy_s[0]  <= '0;
			cz_s[0]  <= ZW'(ang_f) <<< prap_pkg::ANGLE_SHIFT;
			neg_s[0] <= neg_d;
			dx_s[0]  <= DW'(src.point_x) - DW'(src.pivot_x);
			dy_s[0]  <= DW'(src.point_y) - DW'(src.pivot_y);
			pvx_s[0] <= src.pivot_x;
			pvy_s[0] <= src.pivot_y;
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_cordic
		logic signed [XW-1:0] xs;
		logic signed [XW-1:0] ys;

		assign xs = cx_s[i] >>> i;
		assign ys = cy_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (adv) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (!cz_s[i][ZW-1]) begin
					cx_s[i+1] <= cx_s[i] - ys;
					cy_s[i+1] <= cy_s[i] + xs;
				end else begin
					cx_s[i+1] <= cx_s[i] + ys;
					cy_s[i+1] <= cy_s[i] - xs;
				end
				neg_s[i+1] <= neg_s[i];
				dx_s[i+1]  <= dx_s[i];
				dy_s[i+1]  <= dy_s[i];
				pvx_s[i+1] <= pvx_s[i];
				pvy_s[i+1] <= pvy_s[i];
			end
		end

		if (i < NS - 1) begin : g_z
			localparam logic signed [ZW-1:0] ATAN = prap_pkg::atan_step(i);

			always_ff @(posedge clk) begin
				if (adv) begin
					cz_s[i+1] <= cz_s[i][ZW-1] ? cz_s[i] + ATAN : cz_s[i] - ATAN;
				end
			end
		end
	end

	// round cosine and sine to TF fraction bits
	logic signed [XW-1:0] xr_d;
	logic signed [XW-1:0] yr_d;
	logic signed [TW-1:0] cos_d;
	logic signed [TW-1:0] sin_d;

	always_comb begin
		xr_d  = (cx_s[NS] + HALF_X) >>> DROP;
		yr_d  = (cy_s[NS] + HALF_X) >>> DROP;
		cos_d = neg_s[NS] ? -TW'(xr_d) : TW'(xr_d);
		sin_d = neg_s[NS] ? -TW'(yr_d) : TW'(yr_d);
	end

	logic                 v_s26;
	logic signed [TW-1:0] cos_s26;
	logic signed [TW-1:0] sin_s26;
	logic signed [DW-1:0] dx_s26;
	logic signed [DW-1:0] dy_s26;
	logic signed [CW-1:0] pvx_s26;
	logic signed [CW-1:0] pvy_s26;

	logic                 v_s27;
	logic signed [PW-1:0] xc_s27;
	logic signed [PW-1:0] ys_s27;
	logic signed [PW-1:0] xs_s27;
	logic signed [PW-1:0] yc_s27;
	logic signed [CW-1:0] pvx_s27;
	logic signed [CW-1:0] pvy_s27;

	logic                 v_s28;
	logic signed [SW-1:0] sx_s28;
	logic signed [SW-1:0] sy_s28;
	logic signed [CW-1:0] pvx_s28;
	logic signed [CW-1:0] pvy_s28;

	logic                 v_s29;
	prap_pkg::point_rsp_t rsp_s29;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s26 <= 1'b0;
			v_s27 <= 1'b0;
			v_s28 <= 1'b0;
			v_s29 <= 1'b0;
		end else if (adv) begin
			v_s26 <= v_s[NS];
			v_s27 <= v_s26;
			v_s28 <= v_s27;
			v_s29 <= v_s28;
		end
	end

	// add pivot back and clamp
	logic signed [AW-1:0] ax_d;
	logic signed [AW-1:0] ay_d;
	logic signed [CW-1:0] qx_d;
	logic signed [CW-1:0] qy_d;

	always_comb begin
		ax_d = AW'(RW'(sx_s28 >>> TF)) + AW'(pvx_s28);
		ay_d = AW'(RW'(sy_s28 >>> TF)) + AW'(pvy_s28);
		priority if (ax_d > MAX_C) begin
			qx_d = CW'(MAX_C);
		end else if (ax_d < MIN_C) begin
			qx_d = CW'(MIN_C);
		end else begin
			qx_d = CW'(ax_d);
		end
		priority if (ay_d > MAX_C) begin
			qy_d = CW'(MAX_C);
		end else if (ay_d < MIN_C) begin
			qy_d = CW'(MIN_C);
		end else begin
			qy_d = CW'(ay_d);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cos_s26 <= cos_d;
			sin_s26 <= sin_d;
			dx_s26  <= dx_s[NS];
			dy_s26  <= dy_s[NS];
			pvx_s26 <= pvx_s[NS];
			pvy_s26 <= pvy_s[NS];

			xc_s27  <= PW'(dx_s26) * PW'(cos_s26);
			ys_s27  <= PW'(dy_s26) * PW'(sin_s26);
			xs_s27  <= PW'(dx_s26) * PW'(sin_s26);
			yc_s27  <= PW'(dy_s26) * PW'(cos_s26);
			pvx_s27 <= pvx_s26;
			pvy_s27 <= pvy_s26;

			sx_s28  <= SW'(xc_s27) - SW'(ys_s27) + HALF_T;
			sy_s28  <= SW'(xs_s27) + SW'(yc_s27) + HALF_T;
			pvx_s28 <= pvx_s27;
			pvy_s28 <= pvy_s27;

			rsp_s29.rotated_x <= qx_d;
			rsp_s29.rotated_y <= qy_d;
		end
	end

	assign dst_valid = v_s29;
	assign dst       = rsp_s29;

	`PRAP_ASSERT_NEXT(a_entry_valid, clk, arst_n, adv, v_s[0] == $past(src_valid))
	`PRAP_ASSERT_IMPLY(a_cos_range, clk, arst_n, v_s26, cos_s26 <= ONE_T && cos_s26 >= NONE_T)
	`PRAP_ASSERT_IMPLY(a_sin_range, clk, arst_n, v_s26, sin_s26 <= ONE_T && sin_s26 >= NONE_T)
	`PRAP_ASSERT_NEXT(a_clamp_hi, clk, arst_n, adv && v_s28 && ax_d > MAX_C, dst.rotated_x == CW'(MAX_C))

endmodule

// ----- tb/point_rotation_about_pivot_core_tb.sv -----
// Self-checking testbench for point_rotation_about_pivot_core: directed and random requests,
// results predicted by a CORDIC rotation model and checked in order.
// Depends on prap_pkg and the core RTL.
`timescale 1ns / 1ps

module point_rotation_about_pivot_core_tb;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_REQS = 300;
	localparam int CB = prap_pkg::COORD_BITS;
	localparam int AB = prap_pkg::ANGLE_BITS;
	localparam int TF = prap_pkg::TRIG_FRAC_BITS;
	localparam int FULL = prap_pkg::FULL_TURN;
	localparam int HALF = prap_pkg::HALF_TURN;
	localparam int QUARTER = prap_pkg::QUARTER_TURN;

	localparam longint ATAN_DEG_Q16 [prap_pkg::CORDIC_STEPS] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 src_valid = 1'b0;
	logic                 src_stall;
	prap_pkg::point_req_t src = '0;
	logic                 dst_valid;
	logic                 dst_stall = 1'b0;
	prap_pkg::point_rsp_t dst;

	prap_pkg::point_req_t pending_reqs[$];
	prap_pkg::point_rsp_t expected_pts[$];
	int         src_idle_pct = 0;
	int         dst_stall_pct = 0;
	int         mismatches = 0;
	int         quiet_cycles = 0;

	point_rotation_about_pivot_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src      (src),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst      (dst)
	);

	function automatic logic signed [CB-1:0] clamp_coord(longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (CB - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			v = hi;
		end
		if (v < lo) begin
			v = lo;
		end
		return v[CB-1:0];
	endfunction

	function automatic prap_pkg::point_rsp_t rotate_point(prap_pkg::point_req_t r);
		longint     a, x, y, z, nx, ny, c, s, dx, dy, rx, ry, half;
		bit         flip;
		prap_pkg::point_rsp_t p;
		flip = 1'b0;
		a = longint'(r.angle_q4) % FULL;
		if (a > HALF) begin
			a -= FULL;
		end
		if (a > QUARTER) begin
			a -= HALF;
			flip = 1'b1;
		end else if (a < -QUARTER) begin
			a += HALF;
			flip = 1'b1;
		end
		z = a * 4096;
		x = longint'(prap_pkg::CORDIC_GAIN);
		y = 0;
		for (int i = 0; i < prap_pkg::CORDIC_STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z -= ATAN_DEG_Q16[i];
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z += ATAN_DEG_Q16[i];
			end
			x = nx;
			y = ny;
		end
		half = longint'(1) <<< (prap_pkg::CORDIC_FRAC - TF - 1);
		c = (x + half) >>> (prap_pkg::CORDIC_FRAC - TF);
		s = (y + half) >>> (prap_pkg::CORDIC_FRAC - TF);
		if (flip) begin
			c = -c;
			s = -s;
		end
		dx = longint'(r.point_x) - longint'(r.pivot_x);
		dy = longint'(r.point_y) - longint'(r.pivot_y);
		half = longint'(1) <<< (TF - 1);
		rx = (dx * c - dy * s + half) >>> TF;
		ry = (dx * s + dy * c + half) >>> TF;
		p.rotated_x = clamp_coord(longint'(r.pivot_x) + rx);
		p.rotated_y = clamp_coord(longint'(r.pivot_y) + ry);
		return p;
	endfunction

	task automatic add_req(int px, int py, int cx, int cy, int ang);
		prap_pkg::point_req_t r;
		r.point_x = px[CB-1:0];
		r.point_y = py[CB-1:0];
		r.pivot_x = cx[CB-1:0];
		r.pivot_y = cy[CB-1:0];
		r.angle_q4 = ang[AB-1:0];
		pending_reqs.push_back(r);
	endtask

	function automatic prap_pkg::point_req_t random_req();
		prap_pkg::point_req_t r;
		int         pick;
		r.pivot_x = CB'($urandom);
		r.pivot_y = CB'($urandom);
		pick = $urandom_range(99);
		if (pick < 55) begin
			r.point_x = CB'($urandom);
			r.point_y = CB'($urandom);
		end else begin
			// keep the point near the pivot so most results stay in range
			r.point_x = r.pivot_x + CB'($urandom_range(2000) - 1000);
			r.point_y = r.pivot_y + CB'($urandom_range(2000) - 1000);
		end
		pick = $urandom_range(99);
		if (pick < 10) begin
			r.angle_q4 = AB'(QUARTER * $urandom_range(3));
		end else if (pick < 85) begin
			r.angle_q4 = AB'($urandom_range(FULL - 1));
		end else begin
			r.angle_q4 = AB'($urandom_range((1 << AB) - 1, FULL));
		end
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			src <= '0;
		end else if (!src_valid || !src_stall) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				src <= pending_reqs.pop_front();
				src_valid <= 1'b1;
			end else begin
				src_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_stall <= 1'b0;
		end else begin
			dst_stall <= ($urandom_range(99) < dst_stall_pct);
		end
	end

	always @(posedge clk) begin : monitor
		prap_pkg::point_rsp_t want;
		if (arst_n) begin
			if (src_valid && !src_stall) begin
				expected_pts.push_back(rotate_point(src));
			end
			if (dst_valid && !dst_stall) begin
				if (expected_pts.size() == 0) begin
					$display("%0t: result with none expected: x %0d y %0d",
						$time, dst.rotated_x, dst.rotated_y);
					mismatches++;
				end else begin
					want = expected_pts.pop_front();
					if (dst.rotated_x !== want.rotated_x) begin
						$display("%0t: rotated_x expected %0d actual %0d",
							$time, want.rotated_x, dst.rotated_x);
						mismatches++;
					end
					if (dst.rotated_y !== want.rotated_y) begin
						$display("%0t: rotated_y expected %0d actual %0d",
							$time, want.rotated_y, dst.rotated_y);
						mismatches++;
					end
				end
			end
			if ((src_valid && !src_stall) || (dst_valid && !dst_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: timeout with %0d results outstanding", $time,
					expected_pts.size());
				$display("CHECKS FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		add_req(0, 0, 0, 0, 0);
		add_req(32767, 32767, -32768, -32768, 0);
		add_req(32767, 32767, -32768, -32768, QUARTER);
		add_req(32767, 32767, -32768, -32768, HALF);
		add_req(32767, -32768, -32768, 32767, 3 * QUARTER);
		add_req(-32768, -32768, 32767, 32767, 720);
		add_req(-32768, -32768, 32767, 32767, FULL - 1);
		add_req(1234, -4321, 1234, -4321, 1000);
		add_req(100, 0, 0, 0, FULL);
		add_req(100, 0, 0, 0, 7200);
		add_req(100, 0, 0, 0, (1 << AB) - 1);
		add_req(10000, -5000, -3, 7, 1);
		add_req(10000, -5000, -3, 7, QUARTER - 1);
		add_req(10000, -5000, -3, 7, QUARTER + 1);
		add_req(10000, -5000, -3, 7, HALF - 1);
		add_req(10000, -5000, -3, 7, HALF + 1);
		add_req(10000, -5000, -3, 7, 3 * QUARTER - 1);
		add_req(10000, -5000, -3, 7, 3 * QUARTER + 1);
		add_req(1, 0, 0, 0, 960);
		add_req(-1, 1, 0, 0, 480);
		add_req(3, -3, 2, -2, 2160);
		add_req(-32768, 32767, -32768, 32767, 5000);

		for (int phase = 0; phase < 4; phase++) begin
			@(negedge clk);
			case (phase)
				0: begin
					src_idle_pct = 0;
					dst_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 70;
					dst_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					dst_stall_pct = 70;
				end
				default: begin
					src_idle_pct = 29;
					dst_stall_pct = 29;
				end
			endcase
			for (int n = 0; n < PHASE_REQS; n++) begin
				pending_reqs.push_back(random_req());
			end
			while (pending_reqs.size() != 0) begin
				@(negedge clk);
			end
		end

		while (pending_reqs.size() != 0 || src_valid || expected_pts.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
